/* rtl/gwpe_pkg.sv */
`timescale 1ns / 1ps
// gwpe_pkg: shared constants, types and helpers for the gps week-time pivot expander
// no dependencies; used by gps_weektime_pivot_expand

package gwpe_pkg;

    localparam int SECS_PER_WEEK = 7 * 86400;
    localparam int HALF_WEEK     = SECS_PER_WEEK / 2;

    // register map, index = paddr / 4
    localparam logic [1:0] REG_ERA_BASE_WEEK = 2'd0;
    localparam logic [1:0] REG_OFFSET_SECS   = 2'd1;
    localparam logic [1:0] REG_OFFSET_FRAC   = 2'd2;

    // whole weeks and remainder of a floor split by one week
    typedef struct packed {
        logic signed [3:0] weeks;
        logic [19:0]       secs;
    } week_split_t;

    // floor split of a value in -4 .. +3.99 weeks
    function automatic week_split_t week_split(input logic signed [23:0] s);
        week_split_t       res;
        logic signed [3:0]  q;
        logic signed [23:0] base;
        logic signed [23:0] rem;
        q = -4'sd4;
        for (int k = -3; k <= 3; k++)
        begin
            if (s >= $signed(24'(k * SECS_PER_WEEK)))
            begin
                q = 4'(k);
            end
        end
        base = $signed(24'(int'(q) * SECS_PER_WEEK));
        rem = s - base;
        res.weeks = q;
        res.secs = rem[19:0];
        return res;
    endfunction

endpackage

/* rtl/gps_weektime_pivot_expand.sv */
`timescale 1ns / 1ps
// gps_weektime_pivot_expand: unfolds a gps time-of-week around a pivot time
// depends on gwpe_pkg
//
// usage
//  - slave stream (s_*) takes one word per item: raw time of week plus the pivot
//    time (week, seconds, fraction); master stream (m_*) returns one word per item:
//    week number in the configured era, normalized seconds and fraction
//  - apb port holds era_base_week (0x0), offset_secs (0x4), offset_frac (0x8);
//    write these only while no word is in flight
//  - six register stages: a word accepted into stage 1 passes stages 2 to 5 and
//    shows on m_tvalid once it is in the stage 6 output register
//  - throughput one word per cycle while m_tready stays high; stages advance
//    independently, so a bubble anywhere in the pipe keeps s_tready high
//  - when m_tready is low the output word holds and the pipe fills up behind it;
//    s_tready drops only when all six stages hold a word, nothing is lost or doubled
//  - the era fold (distance mod ERA_WEEKS) uses a reciprocal multiply and a
//    multiply-back, each in its own stage, so the 16x32 multiplier sets the pace
//  - reset clears all valid bits and the configuration registers to zero
//  - ERA_WEEKS may be any value in 2..32768

module gps_weektime_pivot_expand #(
    parameter int ERA_WEEKS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // time_of_week[19:0], pivot_week[35:20],
                                   // pivot_secs[57:36], pivot_frac[89:58], zero pad
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // week_number[15:0], week_seconds[35:16],
                                   // second_fraction[67:36], zero pad
);

    // era constants; reciprocal is exact for 16-bit dividends
    localparam logic [15:0] EraWeeks = 16'(ERA_WEEKS);
    localparam logic [31:0] EraRecip =
        32'(((64'd1 << 32) + 64'(ERA_WEEKS) - 64'd1) / 64'(ERA_WEEKS));

    localparam logic [20:0] HalfWeek = 21'(gwpe_pkg::HALF_WEEK);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] era_base_week_reg;
    logic [20:0] offset_secs_reg;
    logic [31:0] offset_frac_reg;
    logic        cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            era_base_week_reg <= '0;
            offset_secs_reg <= '0;
            offset_frac_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                gwpe_pkg::REG_ERA_BASE_WEEK: era_base_week_reg <= pwdata[15:0];
                gwpe_pkg::REG_OFFSET_SECS:   offset_secs_reg <= pwdata[20:0];
                gwpe_pkg::REG_OFFSET_FRAC:   offset_frac_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gwpe_pkg::REG_ERA_BASE_WEEK: prdata = {16'd0, era_base_week_reg};
            gwpe_pkg::REG_OFFSET_SECS:   prdata = {11'd0, offset_secs_reg};
            gwpe_pkg::REG_OFFSET_FRAC:   prdata = offset_frac_reg;
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: each stage loads when empty or when the next one moves
    // ------------------------------------------------------------------
    logic [6:1] vld_reg;
    logic [6:1] vld_next;
    logic [7:1] stage_en;
    logic [6:1] vld_prev;

    always_comb
    begin
        stage_en[7] = m_tready;
        for (int i = 6; i >= 1; i--)
        begin
            stage_en[i] = !vld_reg[i] || stage_en[i + 1];
        end
    end

    assign vld_prev = {vld_reg[5:1], s_tvalid};

    always_comb
    begin
        for (int i = 1; i <= 6; i++)
        begin
            vld_next[i] = stage_en[i] ? vld_prev[i] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = stage_en[1];
    assign m_tvalid = vld_reg[6];

    // ------------------------------------------------------------------
    // stage 1: unpack, add the whole-second offset
    // the fraction is the offset fraction alone, so no carry reaches the seconds
    // ------------------------------------------------------------------
    logic [19:0]        in_tow;
    logic [15:0]        in_pweek;
    logic [21:0]        in_psecs;
    logic [31:0]        in_pfrac;
    logic signed [23:0] secs1_next;

    assign in_tow   = s_tdata[19:0];
    assign in_pweek = s_tdata[35:20];
    assign in_psecs = s_tdata[57:36];
    assign in_pfrac = s_tdata[89:58];

    assign secs1_next = $signed({4'b0000, in_tow})
                      + $signed({{3{offset_secs_reg[20]}}, offset_secs_reg});

    logic signed [23:0] secs1_reg;
    logic signed [23:0] psraw1_reg;
    logic [15:0]        pweek1_reg;
    logic [31:0]        pfrac1_reg;
    logic [31:0]        frac1_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            secs1_reg <= secs1_next;
            psraw1_reg <= $signed({{2{in_psecs[21]}}, in_psecs});
            pweek1_reg <= in_pweek;
            pfrac1_reg <= in_pfrac;
            frac1_reg <= offset_frac_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: floor split of both second counts by one week
    // whole weeks of the time are dropped, those of the pivot move its week
    // ------------------------------------------------------------------
    gwpe_pkg::week_split_t secs_split;
    gwpe_pkg::week_split_t piv_split;
    logic [15:0]           week2_next;

    assign secs_split = gwpe_pkg::week_split(secs1_reg);
    assign piv_split  = gwpe_pkg::week_split(psraw1_reg);
    assign week2_next = pweek1_reg + {{12{piv_split.weeks[3]}}, piv_split.weeks};

    logic [19:0] secs2_reg;
    logic [19:0] psecs2_reg;
    logic [15:0] week2_reg;
    logic [31:0] pfrac2_reg;
    logic [31:0] frac2_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            secs2_reg <= secs_split.secs;
            psecs2_reg <= piv_split.secs;
            week2_reg <= week2_next;
            pfrac2_reg <= pfrac1_reg;
            frac2_reg <= frac1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: pick the week within half a week of the pivot, ties on fraction,
    // then the distance from the era base
    // ------------------------------------------------------------------
    logic [20:0] lim;
    logic [20:0] secs2_ext;
    logic        week_dec;
    logic        week_inc;
    logic [15:0] week_adj;
    logic [15:0] dist3_next;

    assign secs2_ext = {1'b0, secs2_reg};

    always_comb
    begin
        week_dec = 1'b0;
        week_inc = 1'b0;
        if ({1'b0, psecs2_reg} < HalfWeek)
        begin
            // pivot early in its week: time late in the week belongs to the week before
            lim = {1'b0, psecs2_reg} + HalfWeek;
            week_dec = (secs2_ext > lim) || ((secs2_ext == lim) && (frac2_reg >= pfrac2_reg));
        end
        else
        begin
            // pivot late in its week: time early in the week belongs to the week after
            lim = {1'b0, psecs2_reg} - HalfWeek;
            week_inc = (secs2_ext < lim) || ((secs2_ext == lim) && (frac2_reg < pfrac2_reg));
        end
        if (week_dec)
        begin
            week_adj = 16'hFFFF;
        end
        else if (week_inc)
        begin
            week_adj = 16'd1;
        end
        else
        begin
            week_adj = 16'd0;
        end
    end

    assign dist3_next = week2_reg + week_adj - era_base_week_reg;

    logic [15:0] dist3_reg;
    logic [19:0] secs3_reg;
    logic [31:0] frac3_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            dist3_reg <= dist3_next;
            secs3_reg <= secs2_reg;
            frac3_reg <= frac2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: quotient of the distance by the era length via reciprocal
    // ------------------------------------------------------------------
    logic [47:0] prod4_next;

    assign prod4_next = 48'(dist3_reg) * 48'(EraRecip);

    logic [47:0] prod4_reg;
    logic [15:0] dist4_reg;
    logic [19:0] secs4_reg;
    logic [31:0] frac4_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            prod4_reg <= prod4_next;
            dist4_reg <= dist3_reg;
            secs4_reg <= secs3_reg;
            frac4_reg <= frac3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: multiply the quotient back
    // ------------------------------------------------------------------
    logic [15:0] quot4;
    logic [31:0] qe_full;

    assign quot4   = prod4_reg[47:32];
    assign qe_full = 32'(quot4) * 32'(EraWeeks);

    logic [15:0] qe5_reg;
    logic [15:0] dist5_reg;
    logic [19:0] secs5_reg;
    logic [31:0] frac5_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            qe5_reg <= qe_full[15:0];
            dist5_reg <= dist4_reg;
            secs5_reg <= secs4_reg;
            frac5_reg <= frac4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: remainder back onto the era base; output register
    // ------------------------------------------------------------------
    logic [15:0] rem5;
    logic [15:0] week6_next;

    assign rem5       = dist5_reg - qe5_reg;
    assign week6_next = era_base_week_reg + rem5;

    logic [15:0] week6_reg;
    logic [19:0] secs6_reg;
    logic [31:0] frac6_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            week6_reg <= week6_next;
            secs6_reg <= secs5_reg;
            frac6_reg <= frac5_reg;
        end
    end

    assign m_tdata = {4'd0, frac6_reg, secs6_reg, week6_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // seconds leave the pipe normalized into one week
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:16] < 20'(gwpe_pkg::SECS_PER_WEEK)))
        else $error("week_seconds out of range");

    // the reciprocal quotient leaves a remainder below the era length
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> (rem5 < EraWeeks))
        else $error("era remainder not reduced");

    // any empty stage lets a new word in
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg != 6'b111111) |-> s_tready)
        else $error("input stalled with a bubble in the pipe");

    // an output word that is not taken holds its place
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[6] && !m_tready) |=> (vld_reg[6] && $stable(week6_reg)))
        else $error("stalled output word changed");

endmodule
